@@ rtl/core/olpd_pkg.sv @@
// Shared types for the ordered list with positional delete.
// Request and response beats, opcode and status codes, cell command.
// No dependencies.
package olpd_pkg;

	typedef enum logic [1:0] {
		OP_APPEND     = 2'd0,
		OP_DEL_FIRST  = 2'd1,
		OP_DEL_LAST   = 2'd2,
		OP_DEL_AT_POS = 2'd3
	} olpd_op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} olpd_status_t;

	typedef struct packed {
		olpd_op_t           opcode;
		logic signed [31:0] value;
		logic [7:0]         position;
	} olpd_req_t;

	typedef struct packed {
		olpd_status_t       status;
		logic signed [31:0] removed_value;
		logic [4:0]         entry_count;
	} olpd_rsp_t;

	// Broadcast to every cell for one accepted beat.
	typedef struct packed {
		logic app;  // load value into the cell at the index
		logic del;  // cells at or above the index take their right neighbor
	} olpd_cmd_t;

endpackage

@@ rtl/core/ordered_list_with_positional_delete.sv @@
// Ordered list of up to DEPTH signed words with append and positional delete.
// Top level: request decode, count register, chain of cells, response register.
// Depends on olpd_pkg, olpd_ctrl, olpd_cell.
//
// Usage:
//   Drive req and pulse start; a beat is taken at a clock edge with start high
//   and busy low. busy never rises: every request finishes in the cycle it is
//   accepted, so a new request may follow in every cycle.
//   In the cycle after acceptance, done is high for one cycle and rsp carries the
//   status, the removed word (zero unless a delete succeeded) and the new
//   entry count. The receiver cannot stall; rsp is valid only while done.
//   Throughput 1 request per cycle. The limit is the decode
//   of the list count plus the one-hot pick of the removed word across all
//   cells, both settled within the accepting cycle.
//   Each cell holds one entry and on a delete copies its right neighbor, so
//   later entries close the gap at the edge that accepts the delete.
//   Reset empties the list (count to zero) and clears done; cell contents are
//   not cleared and are never read before being written.
module ordered_list_with_positional_delete #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  olpd_pkg::olpd_req_t req,
	output logic               done,
	output olpd_pkg::olpd_rsp_t rsp
);
	import olpd_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                accept;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic [CW-1:0]       idx;
	olpd_status_t        status;
	olpd_cmd_t           cmd;
	logic [31:0]         entries [DEPTH];
	logic [31:0]         picked  [DEPTH];
	logic [31:0]         removed;
	logic [4:0]          count_ext;
	logic                done_q;
	olpd_rsp_t           rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	olpd_ctrl #(
		.DEPTH(DEPTH),
		.CW   (CW)
	) u_ctrl (
		.req      (req),
		.count    (count_q),
		.status   (status),
		.cmd      (cmd),
		.idx      (idx),
		.count_nxt(count_nxt)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] right;
		if (i == DEPTH - 1) begin : g_last
			assign right = entries[i];
		end else begin : g_mid
			assign right = entries[i+1];
		end

		olpd_cell #(
			.CW (CW),
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.en   (accept),
			.cmd  (cmd),
			.idx  (idx),
			.count(count_q),
			.din  (req.value),
			.right(right),
			.entry(entries[i])
		);

		assign picked[i] = (cmd.del && idx == CW'(i)) ? entries[i] : '0;
	end

	// One-hot select: at most one cell is picked.
	always_comb begin
		removed = '0;
		for (int i = 0; i < DEPTH; i++) begin
			removed = removed | picked[i];
		end
	end

	// Response field carries the count modulo 32.
	assign count_ext = 5'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status        <= status;
			rsp_q.removed_value <= removed;
			rsp_q.entry_count   <= count_ext;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no response beat after accepted request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.app) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the list");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == OP_APPEND && count_q == CW'(DEPTH))
		|=> (rsp.status == ST_FULL && $stable(count_q)))
		else $error("append on full list not refused");

endmodule

@@ rtl/core/olpd_cell.sv @@
// One storage cell of the list chain: holds one entry.
// Loads on append, shifts in its right neighbor on delete.
// Depends on olpd_pkg.
module olpd_cell #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               en,
	input  olpd_pkg::olpd_cmd_t cmd,
	input  logic [CW-1:0]      idx,
	input  logic [CW-1:0]      count,
	input  logic [31:0]        din,
	input  logic [31:0]        right,
	output logic [31:0]        entry
);
	import olpd_pkg::*;

	localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
	localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

	logic [31:0] entry_q;
	logic        load;
	logic        shift;

	assign load  = en && cmd.app && (idx == MY_IDX);
	// Only cells that stay inside the shortened list need a new value.
	assign shift = en && cmd.del && (MY_IDX >= idx) && (NEXT_IDX < count);

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= din;
		end else if (shift) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;

endmodule

@@ rtl/core/olpd_ctrl.sv @@
// Request decode: status, cell command, target index and next count.
// Purely combinational; the count register lives in the top level.
// Depends on olpd_pkg.
module olpd_ctrl #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  olpd_pkg::olpd_req_t    req,
	input  logic [CW-1:0]          count,
	output olpd_pkg::olpd_status_t status,
	output olpd_pkg::olpd_cmd_t    cmd,
	output logic [CW-1:0]          idx,
	output logic [CW-1:0]          count_nxt
);
	import olpd_pkg::*;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [8:0] pos9;
	logic [8:0] cnt9;
	logic       empty;

	assign pos9  = {1'b0, req.position};
	assign cnt9  = 9'(count);
	assign empty = (count == '0);

	always_comb begin
		status    = ST_OK;
		cmd       = '0;
		idx       = '0;
		count_nxt = count;
		case (req.opcode)
			OP_APPEND: begin
				if (count >= FULL_CNT) begin
					status = ST_FULL;
				end else begin
					cmd.app   = 1'b1;
					idx       = count;
					count_nxt = count + CW'(1);
				end
			end
			OP_DEL_FIRST: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cmd.del   = 1'b1;
					idx       = '0;
					count_nxt = count - CW'(1);
				end
			end
			OP_DEL_LAST: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cmd.del   = 1'b1;
					idx       = count - CW'(1);
					count_nxt = count - CW'(1);
				end
			end
			OP_DEL_AT_POS: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos9 == 9'd0 || pos9 > cnt9) begin
					status = ST_BADPOS;
				end else begin
					cmd.del   = 1'b1;
					idx       = CW'(pos9 - 9'd1);
					count_nxt = count - CW'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ordered_list_with_positional_delete: directed corner requests,
// then random fill/drain bursts under several sender idle rates. Needs olpd_pkg and the RTL.
module tb;
	import olpd_pkg::*;

	localparam int DEPTH = 16;
	localparam int MAX_GAP = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	olpd_req_t req = '0;
	logic done;
	olpd_rsp_t rsp;

	// shadow copy of the list, updated at each accepted beat
	logic signed [31:0] shadow_words [DEPTH];
	int unsigned shadow_len = 0;
	olpd_rsp_t rsp_expect_q [$];
	int unsigned mismatch_count = 0;
	int unsigned idle_pct = 0;

	ordered_list_with_positional_delete #(.DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Apply one request to the shadow list and return the response it should give.
	function automatic olpd_rsp_t list_apply(olpd_req_t r);
		olpd_rsp_t e;
		int unsigned idx;
		e.status = ST_OK;
		e.removed_value = '0;
		idx = DEPTH;  // DEPTH means nothing gets removed
		if (r.opcode == OP_APPEND) begin
			if (shadow_len >= DEPTH) begin
				e.status = ST_FULL;
			end else begin
				shadow_words[shadow_len] = r.value;
				shadow_len++;
			end
		end else if (shadow_len == 0) begin
			e.status = ST_EMPTY;
		end else if (r.opcode == OP_DEL_FIRST) begin
			idx = 0;
		end else if (r.opcode == OP_DEL_LAST) begin
			idx = shadow_len - 1;
		end else if (r.position == 0 || r.position > shadow_len) begin
			e.status = ST_BADPOS;
		end else begin
			idx = r.position - 1;
		end
		if (idx < DEPTH) begin
			e.removed_value = shadow_words[idx];
			for (int i = idx; i + 1 < shadow_len; i++)
				shadow_words[i] = shadow_words[i + 1];
			shadow_len--;
		end
		e.entry_count = shadow_len[4:0];
		return e;
	endfunction

	function automatic olpd_req_t mk_req(olpd_op_t op, logic signed [31:0] v, logic [7:0] p);
		olpd_req_t r;
		r.opcode = op;
		r.value = v;
		r.position = p;
		return r;
	endfunction

	// Random request; append_pct sets the lean toward filling or draining.
	function automatic olpd_req_t rand_req(int unsigned append_pct);
		olpd_req_t r;
		r.value = $urandom;
		if ($urandom_range(15) == 0)
			r.value = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		// mostly near the valid range so hits and both off-by-one misses are common
		if ($urandom_range(9) < 7)
			r.position = 8'($urandom_range(shadow_len + 1));
		else
			r.position = 8'($urandom_range(255));
		if ($urandom_range(99) < append_pct) begin
			r.opcode = OP_APPEND;
		end else begin
			case ($urandom_range(3))
				0: r.opcode = OP_DEL_FIRST;
				1: r.opcode = OP_DEL_LAST;
				default: r.opcode = OP_DEL_AT_POS;
			endcase
		end
		return r;
	endfunction

	// One beat: optional idle gap, then hold start until accepted. start stays high
	// afterward so back-to-back beats need no extra edge.
	task automatic send_req(input olpd_req_t r);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		rsp_expect_q.push_back(list_apply(r));
	endtask

	always @(posedge clk) begin
		olpd_rsp_t exp_rsp;
		if (arst_n && done) begin
			if (rsp_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected response status=%0d removed=%0d count=%0d",
						$time, rsp.status, rsp.removed_value, rsp.entry_count);
			end else begin
				exp_rsp = rsp_expect_q.pop_front();
				if (rsp.status !== exp_rsp.status ||
				    rsp.removed_value !== exp_rsp.removed_value ||
				    rsp.entry_count !== exp_rsp.entry_count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: exp status=%0d removed=%0d count=%0d, got %0d/%0d/%0d",
							$time, exp_rsp.status, exp_rsp.removed_value,
							exp_rsp.entry_count, rsp.status, rsp.removed_value,
							rsp.entry_count);
				end
			end
		end
	end

	task automatic test_empty_deletes();
		idle_pct = 0;
		send_req(mk_req(OP_DEL_FIRST, 32'h1234_5678, 8'd1));
		send_req(mk_req(OP_DEL_LAST, 32'hffff_ffff, 8'd0));
		send_req(mk_req(OP_DEL_AT_POS, 32'h0, 8'd255));
	endtask

	task automatic test_fill_to_full();
		send_req(mk_req(OP_APPEND, 32'h8000_0000, 8'd0));
		send_req(mk_req(OP_APPEND, 32'h7fff_ffff, 8'd255));
		send_req(mk_req(OP_APPEND, 32'h0000_0000, 8'd1));
		send_req(mk_req(OP_APPEND, 32'hffff_ffff, 8'd16));
		while (shadow_len < DEPTH)
			send_req(mk_req(OP_APPEND, $urandom, 8'($urandom_range(255))));
		// full list refuses the append
		send_req(mk_req(OP_APPEND, 32'h5a5a_5a5a, 8'd0));
	endtask

	task automatic test_positional_edges();
		send_req(mk_req(OP_DEL_AT_POS, 32'h0, 8'd0));
		send_req(mk_req(OP_DEL_AT_POS, 32'h0, 8'd255));
		send_req(mk_req(OP_DEL_AT_POS, 32'h0, 8'd17));
		send_req(mk_req(OP_DEL_AT_POS, 32'h0, 8'd15));
		send_req(mk_req(OP_DEL_AT_POS, 32'h0, 8'd1));
		send_req(mk_req(OP_DEL_FIRST, 32'h0, 8'd0));
		send_req(mk_req(OP_DEL_LAST, 32'h0, 8'd0));
	endtask

	task automatic test_random_mix(input int unsigned pct, input int unsigned n_items);
		int unsigned k;
		idle_pct = pct;
		for (k = 0; k < n_items; k++)
			// 40-beat bursts alternate between filling and draining to reach both ends
			send_req(rand_req(((k / 40) % 2 == 0) ? 70 : 30));
	endtask

	task automatic drain_responses();
		start <= 1'b0;
		while (rsp_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_deletes();
		test_fill_to_full();
		test_positional_edges();
		test_random_mix(0, 275);
		test_random_mix(84, 275);
		test_random_mix(22, 275);
		test_random_mix(0, 275);
		drain_responses();
		if (mismatch_count == 0 && rsp_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
